### rtl/core/card_deck_shuffle_dealer_defines.svh
// Assertion macros shared by the card deck dealer RTL.
`ifndef CARD_DECK_SHUFFLE_DEALER_DEFINES_SVH
`define CARD_DECK_SHUFFLE_DEALER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define CDSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define CDSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/cdsd_pkg.sv
// Shared types, codes and card decode for the card deck dealer.
`timescale 1ns / 1ps
package cdsd_pkg;

  localparam int CODE_W   = 6;
  localparam int RND_W    = 31;
  localparam int REM_W    = 10;
  localparam int CFG_W    = 4;
  localparam int ADD_W    = 10;
  localparam int CARDS_PER_DECK = 52;
  localparam int RANKS_PER_SUIT = 13;

  // operation codes
  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_APPEND  = 2'd1;
  localparam logic [1:0] OP_SHUFFLE = 2'd2;
  localparam logic [1:0] OP_DEAL    = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // configuration register indexes
  localparam logic REG_DECKS  = 1'b0;
  localparam logic REG_PASSES = 1'b1;

  typedef struct packed {
    logic [3:0] rank;
    logic [1:0] suit;
  } card_t;

  // modulo unit status
  typedef struct packed {
    logic busy;
    logic done;
  } mod_status_t;

  // code (0..63) -> rank/suit after reduction modulo 52
  function automatic card_t card_decode(input logic [CODE_W-1:0] raw);
    logic [CODE_W-1:0] code;
    card_t             c;
    code = (raw >= CODE_W'(CARDS_PER_DECK)) ? raw - CODE_W'(CARDS_PER_DECK) : raw;
    if (code >= CODE_W'(3 * RANKS_PER_SUIT)) begin
      c.suit = 2'd3;
      c.rank = 4'(code - CODE_W'(3 * RANKS_PER_SUIT));
    end else if (code >= CODE_W'(2 * RANKS_PER_SUIT)) begin
      c.suit = 2'd2;
      c.rank = 4'(code - CODE_W'(2 * RANKS_PER_SUIT));
    end else if (code >= CODE_W'(RANKS_PER_SUIT)) begin
      c.suit = 2'd1;
      c.rank = 4'(code - CODE_W'(RANKS_PER_SUIT));
    end else begin
      c.suit = 2'd0;
      c.rank = 4'(code);
    end
    return c;
  endfunction

endpackage

### rtl/core/cdsd_mod.sv
// Bit-serial restoring modulo unit: random value modulo card count.
`timescale 1ns / 1ps
module cdsd_mod #(
  parameter int CW = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [cdsd_pkg::RND_W-1:0] dividend,
  input  logic [CW-1:0]              divisor,
  output cdsd_pkg::mod_status_t      stat,
  output logic [CW-1:0]              rem
);
  import cdsd_pkg::*;

  localparam int SW = $clog2(RND_W);

  logic [SW-1:0]    step;
  logic [RND_W-1:0] dvd;
  logic [CW-1:0]    dsr;
  logic [CW:0]      trial;
  logic             busy;
  logic             done;

  // shift in next dividend bit
  assign trial = {rem, dvd[RND_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        dvd  <= dividend;
        dsr  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        dvd  <= {dvd[RND_W-2:0], 1'b0};
        step <= step + SW'(1);
        if (trial >= {1'b0, dsr}) begin
          rem <= CW'(trial - {1'b0, dsr});
        end else begin
          rem <= trial[CW-1:0];
        end
        if (step == SW'(RND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

### rtl/core/cdsd_store.sv
// Card store: one write port, one read port, registered read data.
`timescale 1ns / 1ps
module cdsd_store #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [cdsd_pkg::CODE_W-1:0] wdata,
  input  logic [AW-1:0]               raddr,
  output logic [cdsd_pkg::CODE_W-1:0] rdata
);
  import cdsd_pkg::*;

  logic [CODE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/card_deck_shuffle_dealer.sv
// Card deck dealer top level: control sequencer around the card store.
`timescale 1ns / 1ps
`include "card_deck_shuffle_dealer_defines.svh"
// Stack of card codes (suit*13 + rank) in a MAX_CARDS-deep store, one beat in
// and one result beat out per operation; a new operation is taken once the
// previous one has reached the output register. Clear goes straight to the
// result; deal reads the top entry and decodes it; append writes
// decks_per_fill*52 cards, one store write per cycle; a shuffle step runs the
// bit-serial modulo, then two reads and two writes on the single store port
// pair. The store has no reset; only entries below the current count are used.
module card_deck_shuffle_dealer #(
  parameter int MAX_CARDS = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [30:0] random_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  card_rank,
  output logic [1:0]  card_suit,
  output logic [9:0]  remaining,
  output logic [1:0]  status,
  output logic        shuffle_done
);
  import cdsd_pkg::*;

  localparam int AW = $clog2(MAX_CARDS);
  localparam int CW = $clog2(MAX_CARDS + 1);
  localparam int SW = ((CW > ADD_W) ? CW : ADD_W) + 1;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_FILL = 8'b0000_0010,
    S_MOD  = 8'b0000_0100,
    S_RD_A = 8'b0000_1000,
    S_WR_A = 8'b0001_0000,
    S_WR_B = 8'b0010_0000,
    S_DEAL = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t state;

  logic [CFG_W-1:0]  decks_per_fill;
  logic [CFG_W-1:0]  shuffle_passes;
  logic [CW-1:0]     count;
  logic [AW-1:0]     pos;
  logic [AW-1:0]     target;
  logic [3:0]        pass;
  logic [CODE_W-1:0] card_idx;
  logic [ADD_W-1:0]  fill_left;
  logic [CODE_W-1:0] tmp_a;

  logic [3:0] res_rank;
  logic [1:0] res_suit;
  logic [1:0] res_status;
  logic       res_done;
  logic       res_load;

  logic [ADD_W-1:0]  add_cards;
  logic [SW-1:0]     fill_sum;
  logic [CW-1:0]     pos_inc;
  logic [3:0]        passes_eff;
  logic [CW+9:0]     count_pad;
  card_t             dealt;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CODE_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [CODE_W-1:0] mem_rdata;

  logic              mod_start;
  mod_status_t       mod_stat;
  logic [CW-1:0]     mod_rem;

  assign in_ready   = (state == S_IDLE);
  assign add_cards  = ADD_W'(decks_per_fill) * ADD_W'(CARDS_PER_DECK);
  assign fill_sum   = SW'(count) + SW'(add_cards);
  assign pos_inc    = CW'(pos) + CW'(1);
  assign passes_eff = (shuffle_passes == '0) ? 4'd1 : shuffle_passes;
  assign count_pad  = {10'd0, count};
  assign dealt      = card_decode(mem_rdata);

  // result register loads when the output slot is free or draining
  assign res_load = (state == S_DONE) && (!out_valid || out_ready);

  assign mod_start = (state == S_IDLE) && in_valid && (operation == OP_SHUFFLE)
                     && (count != '0);

  // store address and data select
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos;
    mem_wdata = mem_rdata;
    mem_raddr = pos;
    case (state)
      S_IDLE: begin
        mem_raddr = AW'(count - CW'(1));
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(count);
        mem_wdata = card_idx;
      end
      S_RD_A: begin
        mem_raddr = target;
      end
      S_WR_A: begin
        mem_we = 1'b1;
      end
      S_WR_B: begin
        mem_we    = 1'b1;
        mem_waddr = target;
        mem_wdata = tmp_a;
      end
      default: begin
        mem_raddr = pos;
      end
    endcase
  end

  // sequencer, config registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      count          <= '0;
      pos            <= '0;
      pass           <= '0;
      decks_per_fill <= 4'd1;
      shuffle_passes <= 4'd1;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DECKS:  decks_per_fill <= cfg_data;
          REG_PASSES: shuffle_passes <= cfg_data;
          default:    decks_per_fill <= decks_per_fill;
        endcase
      end
      // result beat leaves unless a new one loads in its place
      if (out_valid && out_ready && !res_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            res_rank   <= '0;
            res_suit   <= '0;
            res_status <= ST_OK;
            res_done   <= 1'b0;
            case (operation)
              OP_CLEAR: begin
                count <= '0;
                pos   <= '0;
                pass  <= '0;
                state <= S_DONE;
              end
              OP_APPEND: begin
                if (fill_sum > SW'(MAX_CARDS)) begin
                  res_status <= ST_FULL;
                  state      <= S_DONE;
                end else begin
                  pos       <= '0;
                  pass      <= '0;
                  card_idx  <= '0;
                  fill_left <= add_cards;
                  state     <= (add_cards == '0) ? S_DONE : S_FILL;
                end
              end
              OP_SHUFFLE: begin
                if (count == '0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_DONE;
                end else begin
                  if (CW'(pos) >= count) begin
                    pos <= '0;
                  end
                  state <= S_MOD;
                end
              end
              default: begin
                if (count == '0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_DONE;
                end else begin
                  count <= count - CW'(1);
                  state <= S_DEAL;
                end
              end
            endcase
          end
        end
        S_FILL: begin
          count     <= count + CW'(1);
          card_idx  <= (card_idx == CODE_W'(CARDS_PER_DECK - 1)) ? '0
                       : card_idx + CODE_W'(1);
          fill_left <= fill_left - ADD_W'(1);
          if (fill_left == ADD_W'(1)) begin
            state <= S_DONE;
          end
        end
        S_MOD: begin
          // read of the walking entry goes out in the cycle the remainder lands
          if (mod_stat.done) begin
            target <= AW'(mod_rem);
            state  <= S_RD_A;
          end
        end
        S_RD_A: begin
          tmp_a <= mem_rdata;
          state <= S_WR_A;
        end
        S_WR_A: begin
          state <= S_WR_B;
        end
        S_WR_B: begin
          // advance walking position, count passes
          if (pos_inc >= count) begin
            pos <= '0;
            if ((pass + 4'd1) >= passes_eff) begin
              res_done <= 1'b1;
              pass     <= '0;
            end else begin
              pass <= pass + 4'd1;
            end
          end else begin
            pos <= AW'(pos_inc);
          end
          state <= S_DONE;
        end
        S_DEAL: begin
          res_rank <= dealt.rank;
          res_suit <= dealt.suit;
          state    <= S_DONE;
        end
        S_DONE: begin
          if (res_load) begin
            out_valid    <= 1'b1;
            card_rank    <= res_rank;
            card_suit    <= res_suit;
            remaining    <= count_pad[9:0];
            status       <= res_status;
            shuffle_done <= res_done;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  cdsd_mod #(
    .CW (CW)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (random_value),
    .divisor  (count),
    .stat     (mod_stat),
    .rem      (mod_rem)
  );

  cdsd_store #(
    .DEPTH (MAX_CARDS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // checks
  `CDSD_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(MAX_CARDS), "card count above capacity")
  `CDSD_ASSERT_NOW(a_fill_room, state == S_FILL, count < CW'(MAX_CARDS), "fill past capacity")
  `CDSD_ASSERT_NOW(a_mod_owner, mod_stat.done, state == S_MOD, "modulo result outside shuffle")
  `CDSD_ASSERT_NOW(a_mod_idle, mod_start, !mod_stat.busy, "modulo restarted while busy")
  `CDSD_ASSERT_NEXT(a_result_out, res_load, out_valid && (state == S_IDLE), "result not presented")

endmodule
